### sv/pf_pkg.sv
`default_nettype none

package pf_pkg;

    // working width of the number being factored
    localparam int VALUE_WIDTH = 16;
    localparam int SQ_WIDTH    = 2 * VALUE_WIDTH;
    localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);
    localparam int UPC_W       = 5;

    localparam logic [31:0] MIN_VALUE = 32'd2;
    localparam logic [31:0] MAX_VALUE = 32'd65000;
    localparam logic [31:0] FIRST_ODD = 32'd3;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_LOAD      = 4'd1,
        OP_HALVE     = 4'd2,
        OP_RECORD    = 4'd3,
        OP_NEXT_D    = 4'd4,
        OP_SQUARE    = 4'd5,
        OP_DIV_START = 4'd6,
        OP_TAKE_Q    = 4'd7,
        OP_TAIL_SET  = 4'd8,
        OP_FLUSH     = 4'd9,
        OP_EMIT_INV  = 4'd10
    } pf_op_t;

    typedef enum logic [2:0] {
        W_NONE = 3'd0,
        W_IN   = 3'd1,
        W_DIV  = 3'd2,
        W_REC  = 3'd3,
        W_OUT  = 3'd4
    } pf_wait_t;

    typedef enum logic [2:0] {
        C_NEXT      = 3'd0,
        C_ALWAYS    = 3'd1,
        C_RANGE_BAD = 3'd2,
        C_N_ODD     = 3'd3,
        C_SQ_GT_N   = 3'd4,
        C_REM_NZ    = 3'd5,
        C_N_LE_2    = 3'd6
    } pf_cond_t;

    typedef struct packed {
        pf_op_t           op;
        pf_wait_t         wt;
        pf_cond_t         cond;
        logic [UPC_W-1:0] target;
    } pf_uword_t;

    // control to the datapath
    typedef struct packed {
        pf_op_t op;
        logic   go;
    } pf_ctrl_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic range_bad;
        logic n_odd;
        logic sq_gt_n;
        logic div_busy;
        logic rem_nz;
        logic n_le_2;
        logic rec_blocked;
        logic out_blocked;
    } pf_status_t;

    // program addresses
    localparam logic [UPC_W-1:0] S_IDLE     = 5'd0;
    localparam logic [UPC_W-1:0] S_CHECK    = 5'd1;
    localparam logic [UPC_W-1:0] S_EVEN     = 5'd2;
    localparam logic [UPC_W-1:0] S_HALVE    = 5'd3;
    localparam logic [UPC_W-1:0] S_REC_TWO  = 5'd4;
    localparam logic [UPC_W-1:0] S_NEXT_D   = 5'd5;
    localparam logic [UPC_W-1:0] S_SQUARE   = 5'd6;
    localparam logic [UPC_W-1:0] S_SQ_TEST  = 5'd7;
    localparam logic [UPC_W-1:0] S_DIV      = 5'd8;
    localparam logic [UPC_W-1:0] S_DIV_WAIT = 5'd9;
    localparam logic [UPC_W-1:0] S_TAKE_Q   = 5'd10;
    localparam logic [UPC_W-1:0] S_REC_D    = 5'd11;
    localparam logic [UPC_W-1:0] S_TAIL     = 5'd12;
    localparam logic [UPC_W-1:0] S_TAIL_SET = 5'd13;
    localparam logic [UPC_W-1:0] S_REC_TAIL = 5'd14;
    localparam logic [UPC_W-1:0] S_FLUSH    = 5'd15;
    localparam logic [UPC_W-1:0] S_INVALID  = 5'd16;

    function automatic pf_uword_t pf_rom(input logic [UPC_W-1:0] addr);
        pf_uword_t w;
        w = '{op: OP_NOP, wt: W_NONE, cond: C_ALWAYS, target: S_IDLE};
        unique case (addr)
            S_IDLE:     w = '{op: OP_LOAD,      wt: W_IN,   cond: C_NEXT,      target: S_IDLE};
            S_CHECK:    w = '{op: OP_NOP,       wt: W_NONE, cond: C_RANGE_BAD, target: S_INVALID};
            S_EVEN:     w = '{op: OP_NOP,       wt: W_NONE, cond: C_N_ODD,     target: S_REC_TWO};
            S_HALVE:    w = '{op: OP_HALVE,     wt: W_NONE, cond: C_ALWAYS,    target: S_EVEN};
            S_REC_TWO:  w = '{op: OP_RECORD,    wt: W_REC,  cond: C_NEXT,      target: S_IDLE};
            S_NEXT_D:   w = '{op: OP_NEXT_D,    wt: W_NONE, cond: C_NEXT,      target: S_IDLE};
            S_SQUARE:   w = '{op: OP_SQUARE,    wt: W_NONE, cond: C_NEXT,      target: S_IDLE};
            S_SQ_TEST:  w = '{op: OP_NOP,       wt: W_NONE, cond: C_SQ_GT_N,   target: S_TAIL};
            S_DIV:      w = '{op: OP_DIV_START, wt: W_NONE, cond: C_NEXT,      target: S_IDLE};
            S_DIV_WAIT: w = '{op: OP_NOP,       wt: W_DIV,  cond: C_REM_NZ,    target: S_REC_D};
            S_TAKE_Q:   w = '{op: OP_TAKE_Q,    wt: W_NONE, cond: C_ALWAYS,    target: S_DIV};
            S_REC_D:    w = '{op: OP_RECORD,    wt: W_REC,  cond: C_ALWAYS,    target: S_NEXT_D};
            S_TAIL:     w = '{op: OP_NOP,       wt: W_NONE, cond: C_N_LE_2,    target: S_FLUSH};
            S_TAIL_SET: w = '{op: OP_TAIL_SET,  wt: W_NONE, cond: C_NEXT,      target: S_IDLE};
            S_REC_TAIL: w = '{op: OP_RECORD,    wt: W_REC,  cond: C_NEXT,      target: S_IDLE};
            S_FLUSH:    w = '{op: OP_FLUSH,     wt: W_OUT,  cond: C_ALWAYS,    target: S_IDLE};
            S_INVALID:  w = '{op: OP_EMIT_INV,  wt: W_OUT,  cond: C_ALWAYS,    target: S_IDLE};
            default:    w = '{op: OP_NOP,       wt: W_NONE, cond: C_ALWAYS,    target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### sv/pf_divider.sv
`default_nettype none

module pf_divider
    import pf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [VALUE_WIDTH-1:0] divisor,
    output logic                        busy,
    output logic [VALUE_WIDTH-1:0]      quotient,
    output logic [VALUE_WIDTH-1:0]      remainder
);

    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH:0]   diff;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        diff      = rem_shift - {1'b0, divisor};
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(VALUE_WIDTH);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[VALUE_WIDTH])
            begin
                rem_next = diff[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### sv/pf_sequencer.sv
`default_nettype none

module pf_sequencer
    import pf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire pf_status_t status,
    output pf_ctrl_t        ctrl
);

    logic [UPC_W-1:0] upc_reg, upc_next;
    pf_uword_t        uword;
    logic             hold;
    logic             take_jump;

    assign uword = pf_rom(upc_reg);

    always_comb
    begin
        unique case (uword.wt)
            W_NONE:  hold = 1'b0;
            W_IN:    hold = !status.in_valid;
            W_DIV:   hold = status.div_busy;
            W_REC:   hold = status.rec_blocked;
            W_OUT:   hold = status.out_blocked;
            default: hold = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (uword.cond)
            C_NEXT:      take_jump = 1'b0;
            C_ALWAYS:    take_jump = 1'b1;
            C_RANGE_BAD: take_jump = status.range_bad;
            C_N_ODD:     take_jump = status.n_odd;
            C_SQ_GT_N:   take_jump = status.sq_gt_n;
            C_REM_NZ:    take_jump = status.rem_nz;
            C_N_LE_2:    take_jump = status.n_le_2;
            default:     take_jump = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (hold)
            upc_next = upc_reg;
        else if (take_jump)
            upc_next = uword.target;
        else
            upc_next = upc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign ctrl.op = uword.op;
    assign ctrl.go = !hold;

endmodule

`default_nettype wire

### sv/prime_factorizer.sv
`default_nettype none

// Prime factorizer: takes one 16-bit unsigned value per input transaction and
// returns its distinct prime factors in ascending order, one output transaction
// per prime, each with its exponent; last marks the final factor of the value.
// A value below 2 or above 65000 returns a single transaction with invalid set
// and zero prime and power. Values are handled one at a time: in_stall stays
// high from acceptance until the last factor has been handed to the output
// register. Work is trial division driven by a small microprogram; every
// division by an odd trial divisor goes through a bit-serial divider. Each
// odd trial divisor tried costs a square, a compare and a divide; each repeated
// removal of a found factor costs a further divide; factors of two are first
// stripped by halving. The worst case, a prime near 65000, tries about 127
// odd divisors. The output register lets the next value be accepted while the
// final factor of the previous one still waits on out_stall.
module prime_factorizer
    import pf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      factor_prime,
    output logic [3:0]       factor_power,
    output logic             last,
    output logic             invalid
);

    pf_ctrl_t   ctrl;
    pf_status_t status;

    // working registers
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [3:0]             e_reg, e_next;
    logic [SQ_WIDTH-1:0]    sq_reg, sq_next;

    // one pending factor, held until we know whether another follows
    logic                   pend_valid_reg, pend_valid_next;
    logic [VALUE_WIDTH-1:0] pend_prime_reg, pend_prime_next;
    logic [3:0]             pend_power_reg, pend_power_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_prime_reg, out_prime_next;
    logic [3:0]             out_power_reg, out_power_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_inv_reg, out_inv_next;

    logic                   div_start;
    logic                   div_busy;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_rem;
    logic                   out_load;
    logic                   out_blocked;
    logic                   do_op;
    logic                   in_accept;

    pf_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    pf_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // only the idle step takes a new transaction
    assign in_stall  = (ctrl.op != OP_LOAD);
    assign in_accept = in_valid && !in_stall;

    assign do_op       = ctrl.go;
    assign div_start   = do_op && (ctrl.op == OP_DIV_START);
    assign out_blocked = out_valid_reg && out_stall;

    always_comb
    begin
        status.in_valid    = in_valid;
        status.range_bad   = (32'(n_reg) < MIN_VALUE) || (32'(n_reg) > MAX_VALUE);
        status.n_odd       = n_reg[0];
        status.sq_gt_n     = (sq_reg > SQ_WIDTH'(n_reg));
        status.div_busy    = div_busy;
        status.rem_nz      = (div_rem != '0);
        status.n_le_2      = (32'(n_reg) <= MIN_VALUE);
        // recording a new factor pushes the pending one out
        status.rec_blocked = (e_reg != '0) && pend_valid_reg && out_blocked;
        status.out_blocked = out_blocked;
    end

    always_comb
    begin
        n_next          = n_reg;
        d_next          = d_reg;
        e_next          = e_reg;
        sq_next         = sq_reg;
        pend_valid_next = pend_valid_reg;
        pend_prime_next = pend_prime_reg;
        pend_power_next = pend_power_reg;
        out_load        = 1'b0;
        out_prime_next  = out_prime_reg;
        out_power_next  = out_power_reg;
        out_last_next   = out_last_reg;
        out_inv_next    = out_inv_reg;

        if (do_op)
        begin
            unique case (ctrl.op)
                OP_NOP:
                begin
                end
                OP_LOAD:
                begin
                    n_next          = VALUE_WIDTH'(value);
                    d_next          = VALUE_WIDTH'(MIN_VALUE);
                    e_next          = '0;
                    pend_valid_next = 1'b0;
                end
                OP_HALVE:
                begin
                    n_next = n_reg >> 1;
                    e_next = e_reg + 1'b1;
                end
                OP_RECORD:
                begin
                    if (e_reg != '0)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load       = 1'b1;
                            out_prime_next = pend_prime_reg;
                            out_power_next = pend_power_reg;
                            out_last_next  = 1'b0;
                            out_inv_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_prime_next = d_reg;
                        pend_power_next = e_reg;
                    end
                    e_next = '0;
                end
                OP_NEXT_D:
                begin
                    // two steps to three, then odd divisors only
                    if (d_reg[0])
                        d_next = d_reg + VALUE_WIDTH'(2);
                    else
                        d_next = VALUE_WIDTH'(FIRST_ODD);
                end
                OP_SQUARE:
                begin
                    sq_next = SQ_WIDTH'(d_reg) * SQ_WIDTH'(d_reg);
                end
                OP_DIV_START:
                begin
                end
                OP_TAKE_Q:
                begin
                    n_next = div_quo;
                    e_next = e_reg + 1'b1;
                end
                OP_TAIL_SET:
                begin
                    // leftover above two is itself prime
                    d_next = n_reg;
                    e_next = 4'd1;
                end
                OP_FLUSH:
                begin
                    out_load        = 1'b1;
                    out_prime_next  = pend_prime_reg;
                    out_power_next  = pend_power_reg;
                    out_last_next   = 1'b1;
                    out_inv_next    = 1'b0;
                    pend_valid_next = 1'b0;
                end
                OP_EMIT_INV:
                begin
                    out_load       = 1'b1;
                    out_prime_next = '0;
                    out_power_next = '0;
                    out_last_next  = 1'b1;
                    out_inv_next   = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        priority if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        d_reg          <= d_next;
        e_reg          <= e_next;
        sq_reg         <= sq_next;
        pend_prime_reg <= pend_prime_next;
        pend_power_reg <= pend_power_next;
        out_prime_reg  <= out_prime_next;
        out_power_reg  <= out_power_next;
        out_last_reg   <= out_last_next;
        out_inv_reg    <= out_inv_next;
    end

    assign out_valid    = out_valid_reg;
    assign factor_prime = 16'(out_prime_reg);
    assign factor_power = out_power_reg;
    assign last         = out_last_reg;
    assign invalid      = out_inv_reg;

    // a new transaction closes the input until the microprogram returns
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
    else $error("input taken again right after acceptance");

    // the divider is never restarted mid division
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
    else $error("divider started while busy");

    // output register is never overwritten while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_blocked)
    else $error("output register overwritten while stalled");

    // an error result carries no factor
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && invalid) |-> (factor_prime == '0 && factor_power == '0 && last))
    else $error("malformed invalid result");

    // a real factor is at least two with a nonzero exponent
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !invalid) |-> (factor_power != '0 && factor_prime >= 16'd2))
    else $error("malformed factor result");

endmodule

`default_nettype wire

### tb/prime_factorizer_checker.sv
`default_nettype none

module prime_factorizer_checker
    import pf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [15:0] value,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [15:0] factor_prime,
    input  wire logic [3:0]  factor_power,
    input  wire logic        last,
    input  wire logic        invalid,
    output int               fail_count,
    output int               pending
);

    typedef struct {
        logic [15:0] source;
        logic [15:0] prime;
        logic [3:0]  power;
        logic        last;
        logic        invalid;
    } factor_t;

    factor_t factors_due[$];
    factor_t want;
    int      errors = 0;

    // trial division, one entry per distinct prime in ascending order
    function automatic void factorize(input logic [15:0] v);
        factor_t     found[$];
        logic [31:0] n;
        logic [31:0] d;
        int          e;
        n = {16'd0, v};
        if (n < MIN_VALUE || n > MAX_VALUE)
        begin
            factors_due.push_back('{v, 16'd0, 4'd0, 1'b1, 1'b1});
            return;
        end
        e = 0;
        while (n[0] == 1'b0)
        begin
            e++;
            n = n >> 1;
        end
        if (e > 0)
            found.push_back('{v, 16'd2, 4'(e), 1'b0, 1'b0});
        for (d = FIRST_ODD; d * d <= n; d += 2)
        begin
            e = 0;
            while (n % d == 0)
            begin
                e++;
                n = n / d;
            end
            if (e > 0)
                found.push_back('{v, d[15:0], 4'(e), 1'b0, 1'b0});
        end
        // leftover above two is a prime of its own
        if (n > MIN_VALUE)
            found.push_back('{v, n[15:0], 4'd1, 1'b0, 1'b0});
        found[found.size() - 1].last = 1'b1;
        foreach (found[k])
            factors_due.push_back(found[k]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factors_due.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (factors_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("error: unexpected factor prime=%0d power=%0d last=%0b inv=%0b",
                                 factor_prime, factor_power, last, invalid);
                end
                else
                begin
                    want = factors_due.pop_front();
                    if (factor_prime !== want.prime || factor_power !== want.power ||
                        last !== want.last || invalid !== want.invalid)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $write("error: value %0d expected prime=%0d power=%0d last=%0b inv=%0b, ",
                                   want.source, want.prime, want.power, want.last,
                                   want.invalid);
                            $display("got prime=%0d power=%0d last=%0b inv=%0b",
                                     factor_prime, factor_power, last, invalid);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                factorize(value);
            pending    <= factors_due.size();
            fail_count <= errors;
        end
    end

endmodule

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench
    import pf_pkg::*;
();

    // a prime near the top of the range moves no transaction on either side
    // for its whole factorization, and runs of an 87% receiver stall are far
    // shorter than that, so this leaves a wide margin
    localparam int QUIET_LIMIT     = 20000;
    // once nothing is expected, watch this long for stray factors
    localparam int DRAIN_CYCLES    = 3000;
    localparam int ITEMS_PER_PHASE = 55;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [15:0] value     = 16'd0;
    logic        out_stall = 1'b0;
    wire logic   in_stall;
    wire logic   out_valid;
    wire logic [15:0] factor_prime;
    wire logic [3:0]  factor_power;
    wire logic   last;
    wire logic   invalid;

    int fail_count;
    int pending;
    int quiet_cycles = 0;

    // percent chance per cycle of a sender gap and of a receiver stall
    int idle_pct  = 0;
    int stall_pct = 0;

    // corners: out of range on both sides, range ends, small primes,
    // square of a prime, top exponent, six distinct primes, leftover prime
    logic [15:0] corner_values[$] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd9, 16'd10, 16'd49,
        16'd30030, 16'd32768, 16'd59049, 16'd15625, 16'd63001, 16'd32749,
        16'd64997, 16'd65000, 16'd65001, 16'd65535, 16'd46189, 16'd65534
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    prime_factorizer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .factor_prime (factor_prime),
        .factor_power (factor_power),
        .last         (last),
        .invalid      (invalid)
    );

    prime_factorizer_checker factor_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .factor_prime (factor_prime),
        .factor_power (factor_power),
        .last         (last),
        .invalid      (invalid),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // receiver back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(99, 0) < stall_pct);

    // watchdog: cycles in which neither side moves a transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT - 1)
        begin
            $display("prime_factorizer: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // random gaps, then hold the value until it is taken
    task automatic offer_value(input logic [15:0] v);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop sending until every outstanding factor has come back
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // mostly small or smooth numbers to keep trial division short, plus
    // out of range noise and a share of the full input space
    function automatic logic [15:0] pick_value();
        int          kind;
        logic [31:0] n;
        int          f;
        kind = $urandom_range(99, 0);
        n    = 32'd1;
        if (kind < 10)
        begin
            // out of range, low or high
            if ($urandom_range(1, 0) == 0)
                n = $urandom_range(1, 0);
            else
                n = $urandom_range(65535, 65001);
        end
        else if (kind < 35)
            n = $urandom_range(1023, 2);
        else if (kind < 55)
        begin
            // power of one small base, reaching high exponents
            f = $urandom_range(7, 2);
            repeat ($urandom_range(15, 1))
                if (n * f <= MAX_VALUE)
                    n = n * f;
        end
        else if (kind < 78)
        begin
            // product of small factors, sometimes with a large cofactor
            repeat ($urandom_range(8, 1))
            begin
                f = $urandom_range(53, 2);
                if (n * f <= MAX_VALUE)
                    n = n * f;
            end
            if ($urandom_range(3, 0) == 0)
                n = n * $urandom_range(MAX_VALUE / n, 1);
        end
        else
            n = $urandom_range(65535, 0);
        if (n < MIN_VALUE && kind >= 10)
            n = MIN_VALUE;
        return n[15:0];
    endfunction

    initial
    begin
        int phase;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 4; phase++)
        begin
            // phases: steady flow, sparse sender, heavy stall, light mix
            unique case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 87;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 87;
                end
                default:
                begin
                    idle_pct  = 25;
                    stall_pct = 25;
                end
            endcase
            hold_until_drained();
            if (phase == 0)
                foreach (corner_values[k])
                    offer_value(corner_values[k]);
            repeat (ITEMS_PER_PHASE)
                offer_value(pick_value());
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("prime_factorizer: match");
        else
            $display("prime_factorizer: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
sv/pf_pkg.sv
sv/pf_divider.sv
sv/pf_sequencer.sv
sv/prime_factorizer.sv
tb/prime_factorizer_checker.sv
tb/testbench.sv
